// ===== rtl/core/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg: shared constants, types and the tanh table
// Holds the table size, the fixed-point widths that cross module boundaries
// and the elaboration-time builder for the Q.24 tanh table.
// ----------------------------------------------------------------------------
package tws_pkg;

  // Number of table intervals over the argument span [0, 4).
  localparam int TANH_TABLE_ENTRIES = 256;

  // The argument is Q.24, so the span of 4.0 covers 26 bits.
  localparam int SPAN_SHIFT = 26;
  localparam int TAB_ADDR_W = $clog2(TANH_TABLE_ENTRIES + 1);
  localparam int POS_W      = SPAN_SHIFT + TAB_ADDR_W;

  // Widths of the datapath.
  localparam int ARG_W    = 35;  // signed Q.24 tanh argument
  localparam int TANH_W   = 26;  // signed Q.24 tanh value, within +-1.0
  localparam int TVAL_W   = 25;  // unsigned table entry, up to 1.0
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAL   = 2'd3;

  localparam logic [TVAL_W-1:0] ONE_Q24   = TVAL_W'(1 << 24);
  localparam logic [ARG_W-1:0]  SPAN_LIMIT = ARG_W'(64'd4 << 24);

  typedef logic [TVAL_W-1:0] tanh_val_t;
  typedef tanh_val_t tanh_tab_t [TANH_TABLE_ENTRIES + 1];

  // Shift-subtract division, used only while the table is elaborated.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // r = exp(-8/N) by a Taylor series in Q.32 with floored terms, then
  // E_k = r^k with rounded Q.32 products and tanh_k = (1-E_k)/(1+E_k) in Q.24.
  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t tab;
    logic [63:0] h;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] quo;
    logic [127:0] wide;
    h    = udiv64(64'h8_0000_0000, 64'(TANH_TABLE_ENTRIES));
    term = 64'h1_0000_0000;
    sum  = 64'sh1_0000_0000;
    for (int i = 1; i < 40; i++) begin
      term = udiv64((term * h) >> 32, 64'(i));
      if (i % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    r = $unsigned(sum);
    e = 64'h1_0000_0000;
    for (int k = 0; k <= TANH_TABLE_ENTRIES; k++) begin
      quo    = udiv64((64'h1_0000_0000 - e) << 24, 64'h1_0000_0000 + e);
      tab[k] = quo[TVAL_W-1:0];
      wide   = {64'd0, e} * {64'd0, r};
      wide   = wide + 128'h8000_0000;
      e      = wide[95:32];
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

// ===== rtl/core/tanh_waveshaper_mix.sv =====
// ----------------------------------------------------------------------------
// tanh_waveshaper_mix: tanh soft-clip distortion with dry/shaped mix
// Pipeline: seven register stages from the input to out_valid; the two
// multiplier stages and the three-stage tanh units set the stage count.
// Throughput: one sample per cycle unless the output stalls; each stage loads
// whenever it is empty or its successor loads, and holds its contents when
// stalled. Reset clears every valid bit and the configuration registers;
// the data registers are not reset, as only valid-qualified data counts.
// ----------------------------------------------------------------------------
module tanh_waveshaper_mix (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tws_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [15:0]                  sample_in,
  input  logic                                block_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [15:0]                  sample_out,
  output logic                                clipped,
  output logic                                block_end_out
);
  import tws_pkg::*;

  // Configuration registers; the user must write them only while the pipeline is empty, the block does not enforce it.
  logic [15:0]        gain_coef;
  logic [15:0]        drive_amount;
  logic signed [15:0] bias_offset;
  logic [16:0]        dry_balance;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_coef    <= 16'd4096;
      drive_amount <= 16'd4096;
      bias_offset  <= '0;
      dry_balance  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN:  gain_coef    <= cfg_data[15:0];
        REG_DRIVE: drive_amount <= cfg_data[15:0];
        REG_BIAS:  bias_offset  <= $signed(cfg_data[15:0]);
        REG_BAL:   dry_balance  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Per-stage flow control. A stage may load whenever it is empty or its
  // successor is loading, so bubbles are squeezed out while the output is
  // stalled and nothing is dropped or duplicated.
  logic [7:1] vld;
  logic [7:1] rdy;

  always_comb begin
    rdy[7] = ~vld[7] | out_ready;
    for (int i = 6; i >= 1; i--) begin
      rdy[i] = ~vld[i] | rdy[i+1];
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = vld[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int i = 2; i <= 7; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1: the dry term, sample times input gain (Q.27, exact).
  logic signed [31:0] s1_dry;
  logic               s1_end;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_dry <= 32'(sample_in * $signed({1'b0, gain_coef}));
      s1_end <= block_end;
    end
  end

  // Stage 2: the drive product (Q.39); it never exceeds 47 magnitude bits.
  logic signed [47:0] s2_prod;
  logic signed [31:0] s2_dry;
  logic               s2_end;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_prod <= 48'(s1_dry * $signed({1'b0, drive_amount}));
      s2_dry  <= s1_dry;
      s2_end  <= s1_end;
    end
  end

  // Stages 3 to 5: the tanh argument is the drive product floored to Q.24
  // plus the bias; the bias alone goes through a second shaper so that the
  // DC shift it causes can be removed again.
  logic signed [ARG_W-1:0]  arg;
  logic signed [ARG_W-1:0]  bias24;
  logic signed [TANH_W-1:0] tanh_arg;
  logic signed [TANH_W-1:0] tanh_bias;
  logic signed [47:0]       prod_q24;

  always_comb begin
    prod_q24 = s2_prod >>> 15;
    bias24   = {{(ARG_W-28){bias_offset[15]}}, bias_offset, 12'd0};
    arg      = ARG_W'(prod_q24) + bias24;
  end

  tws_tanh u_tanh_arg (
    .clk (clk),
    .en  (rdy[5:3]),
    .arg (arg),
    .y   (tanh_arg)
  );

  tws_tanh u_tanh_bias (
    .clk (clk),
    .en  (rdy[5:3]),
    .arg (bias24),
    .y   (tanh_bias)
  );

  logic signed [31:0] s3_dry;
  logic signed [31:0] s4_dry;
  logic signed [31:0] s5_dry;
  logic               s3_end;
  logic               s4_end;
  logic               s5_end;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_dry <= s2_dry;
      s3_end <= s2_end;
    end
    if (rdy[4]) begin
      s4_dry <= s3_dry;
      s4_end <= s3_end;
    end
    if (rdy[5]) begin
      s5_dry <= s4_dry;
      s5_end <= s4_end;
    end
  end

  // Stage 6: weight both paths. A balance above one counts as all dry.
  logic [16:0]        bal_eff;
  logic [16:0]        wet_share;
  logic signed [26:0] shaped;
  logic signed [44:0] s6_wet;
  logic signed [49:0] s6_dry;
  logic               s6_end;

  always_comb begin
    bal_eff   = (dry_balance > 17'd65536) ? 17'd65536 : dry_balance;
    wet_share = 17'd65536 - bal_eff;
    shaped    = 27'(tanh_arg) - 27'(tanh_bias);
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_wet <= 45'(shaped * $signed({1'b0, wet_share}));
      s6_dry <= 50'(s5_dry * $signed({1'b0, bal_eff}));
      s6_end <= s5_end;
    end
  end

  // Stage 7: sum in Q.43, round half up to Q.15 and saturate.
  logic signed [49:0] acc;
  logic signed [49:0] res_full;
  logic signed [15:0] res_sat;
  logic               res_clip;

  always_comb begin
    acc      = (50'(s6_wet) <<< 3) + s6_dry + 50'sd134217728;
    res_full = acc >>> 28;
    res_clip = 1'b0;
    res_sat  = res_full[15:0];
    if (res_full > 50'sd32767) begin
      res_sat  = 16'sh7fff;
      res_clip = 1'b1;
    end else if (res_full < -50'sd32768) begin
      res_sat  = -16'sh8000;
      res_clip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      sample_out    <= res_sat;
      clipped       <= res_clip;
      block_end_out <= s6_end;
    end
  end

`ifndef SYNTHESIS
  // With the sink ready every stage can move on, so the input must be open.
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked although the output side is ready");

  // A clipped result carries one of the two full-scale codes.
  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> (sample_out == 16'sh7fff || sample_out == -16'sh8000))
    else $error("clip flag set on an unsaturated sample");

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline holds data after reset");
`endif

endmodule

// ===== rtl/core/tws_tanh.sv =====
// ----------------------------------------------------------------------------
// tws_tanh: three-stage interpolated tanh
// Folds the argument to its magnitude, reads two neighbouring table entries
// and interpolates linearly, restoring the sign at the end.
// ----------------------------------------------------------------------------
module tws_tanh (
  input  logic                              clk,
  input  logic [2:0]                        en,
  input  logic signed [tws_pkg::ARG_W-1:0]  arg,
  output logic signed [tws_pkg::TANH_W-1:0] y
);
  import tws_pkg::*;

  logic [ARG_W-1:0]      mag;
  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      a_pos;
  logic                  a_sat;
  logic                  a_neg;

  logic [TAB_ADDR_W-1:0] idx;
  logic [TAB_ADDR_W-1:0] idx_hi;
  tanh_val_t             lo;
  tanh_val_t             hi;
  tanh_val_t             b_lo;
  tanh_val_t             b_diff;
  logic [SPAN_SHIFT-1:0] b_frac;
  logic                  b_sat;
  logic                  b_neg;

  logic [TVAL_W+SPAN_SHIFT-1:0] ip;
  tanh_val_t                    ymag;

  // Stage A: magnitude, range check and position within the table.
  always_comb begin
    mag = arg[ARG_W-1] ? ARG_W'(-arg) : ARG_W'(arg);
    pos = POS_W'(mag[SPAN_SHIFT-1:0]) * POS_W'(TANH_TABLE_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_pos <= pos;
      a_sat <= (mag >= SPAN_LIMIT);
      a_neg <= arg[ARG_W-1];
    end
  end

  // Stage B: table read of both neighbours.
  always_comb begin
    idx = a_pos[SPAN_SHIFT +: TAB_ADDR_W];
    if (idx >= TAB_ADDR_W'(TANH_TABLE_ENTRIES)) begin
      idx = TAB_ADDR_W'(TANH_TABLE_ENTRIES - 1);
    end
    idx_hi = idx + TAB_ADDR_W'(1);
    lo     = TANH_TAB[idx];
    hi     = TANH_TAB[idx_hi];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_lo   <= lo;
      b_diff <= (hi > lo) ? (hi - lo) : '0;
      b_frac <= a_pos[SPAN_SHIFT-1:0];
      b_sat  <= a_sat;
      b_neg  <= a_neg;
    end
  end

  // Stage C: interpolation and sign.
  always_comb begin
    ip   = (TVAL_W+SPAN_SHIFT)'(b_diff) * (TVAL_W+SPAN_SHIFT)'(b_frac);
    ymag = b_sat ? ONE_Q24 : (b_lo + ip[SPAN_SHIFT +: TVAL_W]);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      y <= b_neg ? -$signed({1'b0, ymag}) : $signed({1'b0, ymag});
    end
  end

endmodule

// ===== verif/tb_tanh_waveshaper_mix.sv =====
// ----------------------------------------------------------------------------
// tb_tanh_waveshaper_mix: self-checking bench for the tanh waveshaper and mix
// A directed table covers reset settings, the rails, balance clamping, the
// table span, the bias extremes and oversized register writes. A random part
// follows over several register settings and handshake pressure profiles.
// Every result is compared against a typed value or a bit-accurate predictor.
// ----------------------------------------------------------------------------
module tb_tanh_waveshaper_mix;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 12;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PIPE_DEPTH      = 7;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLD_CYCLES     = 80;
  localparam int PRINT_CAP       = 60;

  // Table geometry follows the block's package so the two tables agree in size.
  localparam int TAB_N     = tws_pkg::TANH_TABLE_ENTRIES;
  localparam int SPAN_BITS = 26;
  localparam longint UNITY_Q24   = 64'sd16777216;
  localparam longint ROUND_Q28   = 64'sd134217728;
  localparam longint ALL_DRY     = 64'sd65536;

  // One result transaction as the block presents it.
  typedef struct packed {
    logic signed [15:0] sample;
    logic               clip;
    logic               blk_end;
  } mix_result_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  // One line of the directed table: either a register write or a sample,
  // with the expected result typed in only where it is obvious.
  typedef struct packed {
    row_kind_t                         kind;
    logic [tws_pkg::CFG_IDX_W-1:0]     reg_idx;
    logic [tws_pkg::CFG_DATA_W-1:0]    reg_val;
    logic signed [15:0]                sample;
    logic                              blk_end;
    logic                              typed;
    logic signed [15:0]                want_sample;
    logic                              want_clip;
  } stim_row_t;

  // Every input of the block starts at a known value.
  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_we    = 1'b0;
  logic [tws_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [tws_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  logic signed [15:0]              sample_in = '0;
  logic                            block_end = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic signed [15:0]              sample_out;
  logic                            clipped;
  logic                            block_end_out;

  // The bench's own copy of the registers, updated as they are written.
  logic [15:0]        gain_q412  = 16'd4096;
  logic [15:0]        drive_q412 = 16'd4096;
  logic signed [15:0] bias_q312  = '0;
  logic [16:0]        dry_share  = '0;

  logic [24:0]  tanh_lut [0:TAB_N];
  mix_result_t  pending_mix [$];

  int mismatches    = 0;
  int results_seen  = 0;
  int items_sent    = 0;
  int reg_writes    = 0;
  int input_stalls  = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  tanh_waveshaper_mix dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_in     (sample_in),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_out    (sample_out),
    .clipped       (clipped),
    .block_end_out (block_end_out)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Q.24 tanh table over [0, 4): r = exp(-8/N) from a floored Taylor series in
  // Q.32, powers of r by rounded Q.32 products, then (1 - E) / (1 + E).
  function automatic void build_tanh_lut();
    longint unsigned step_h, term, r, e;
    longint          sum;
    step_h = (64'd8 << 32) / TAB_N;
    term   = 64'd1 << 32;
    sum    = longint'(term);
    for (int i = 1; i < 40; i++) begin
      term = ((term * step_h) >> 32) / 64'(i);
      if (i % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    r = sum;
    e = 64'd1 << 32;
    for (int k = 0; k <= TAB_N; k++) begin
      tanh_lut[k] = 25'((((64'd1 << 32) - e) << 24) / ((64'd1 << 32) + e));
      e = (e * r + (64'd1 << 31)) >> 32;
    end
  endfunction

  // Interpolated tanh of a Q.24 argument, odd symmetric, exactly one beyond
  // the span of the table.
  function automatic longint tanh_q24_pred(input longint arg);
    longint unsigned mag, pos, idx, frac, lo, hi;
    longint          y;
    mag = (arg < 0) ? -arg : arg;
    if (mag >= (64'd4 << 24)) begin
      y = UNITY_Q24;
    end else begin
      pos  = mag * TAB_N;
      idx  = pos >> SPAN_BITS;
      frac = pos & ((64'd1 << SPAN_BITS) - 1);
      if (idx >= TAB_N) begin
        idx = TAB_N - 1;
      end
      lo = tanh_lut[idx];
      hi = tanh_lut[idx + 1];
      y  = longint'(lo);
      if (hi > lo) begin
        y = y + longint'(((hi - lo) * frac) >> SPAN_BITS);
      end
    end
    return (arg < 0) ? -y : y;
  endfunction

  // Expected result of one sample under the current register copy.
  function automatic mix_result_t predict_mix(input logic signed [15:0] smp,
                                              input logic be);
    longint      x, g, d, b, dry, prod, bias24, arg, shaped, bal, acc, res;
    mix_result_t r;
    x      = smp;
    g      = gain_q412;
    d      = drive_q412;
    b      = bias_q312;
    bal    = dry_share;
    dry    = x * g;
    prod   = dry * d;
    bias24 = b * 4096;
    arg    = (prod >>> 15) + bias24;
    shaped = tanh_q24_pred(arg) - tanh_q24_pred(bias24);
    if (bal > ALL_DRY) begin
      bal = ALL_DRY;
    end
    acc    = shaped * (ALL_DRY - bal) * 8 + dry * bal;
    res    = (acc + ROUND_Q28) >>> 28;
    r.clip = 1'b0;
    if (res > 32767) begin
      res    = 32767;
      r.clip = 1'b1;
    end else if (res < -32768) begin
      res    = -32768;
      r.clip = 1'b1;
    end
    r.sample  = res[15:0];
    r.blk_end = be;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [tws_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [tws_pkg::CFG_DATA_W-1:0] val);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t smp_row(input logic signed [15:0] smp, input logic be);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_SAMPLE;
    r.sample  = smp;
    r.blk_end = be;
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic signed [15:0] smp, input logic be,
                                          input logic signed [15:0] want,
                                          input logic clip);
    stim_row_t r;
    r             = smp_row(smp, be);
    r.typed       = 1'b1;
    r.want_sample = want;
    r.want_clip   = clip;
    return r;
  endfunction

  // Prints one line per mismatch, up to a cap, and always counts.
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Register writes only happen with the pipeline empty. Each write holds the
  // enable for one edge and drops it on the next, so consecutive writes never
  // assign the enable twice in one time step.
  task automatic write_reg(input logic [tws_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tws_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      tws_pkg::REG_GAIN:  gain_q412  = val[15:0];
      tws_pkg::REG_DRIVE: drive_q412 = val[15:0];
      tws_pkg::REG_BIAS:  bias_q312  = val[15:0];
      tws_pkg::REG_BAL:   dry_share  = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Lowers valid after the last transaction and waits for every outstanding
  // result. The block returns exactly one result per sample, so an empty store
  // of expectations means an empty pipeline.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_mix.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Offers one sample after a random gap and records what it should produce
  // once the transaction is accepted. Valid stays high between back-to-back
  // transactions; only the payload changes.
  task automatic offer_sample(input logic signed [15:0] smp, input logic be,
                              input mix_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= smp;
    block_end <= be;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pending_mix.push_back(want);
    items_sent++;
  endtask

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_mix.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver. Stalls at random according to the current profile, and on
  // request holds ready low for a long stretch so that the pipeline fills
  // and the block has to push back on its input.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker. Values are sampled at the edge, before any of the
  // nonblocking updates of that edge land, so ordering within the step does
  // not matter. Each accepted result is matched against the oldest
  // expectation field by field.
  always @(posedge clk) begin
    mix_result_t want;
    if (!rst && in_valid && !in_ready) begin
      input_stalls++;
    end
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_mix.size() == 0) begin
        report_mismatch($sformatf("result %0d (sample_out %0d) with nothing outstanding",
                                  results_seen, sample_out));
      end else begin
        want = pending_mix.pop_front();
        if (sample_out !== want.sample) begin
          report_mismatch($sformatf("result %0d sample_out %0d, expected %0d",
                                    results_seen, sample_out, want.sample));
        end
        if (clipped !== want.clip) begin
          report_mismatch($sformatf("result %0d clipped %b, expected %b",
                                    results_seen, clipped, want.clip));
        end
        if (block_end_out !== want.blk_end) begin
          report_mismatch($sformatf("result %0d block_end_out %b, expected %b",
                                    results_seen, block_end_out, want.blk_end));
        end
      end
    end
  end

  // Stimulus: directed table first, then random phases, then the drain.
  initial begin
    stim_row_t                       rows [$];
    mix_result_t                     want;
    logic signed [15:0]              smp;
    logic                            be;
    logic [tws_pkg::CFG_DATA_W-1:0]  gv, dv, bv, av;
    int                              drain;

    build_tanh_lut();

    rows = '{
      // Reset settings: unity gain and drive, no bias, fully shaped. Zero in
      // gives zero out; the other values go through the predictor.
      known_row(16'sd0, 1'b0, 16'sd0, 1'b0),
      smp_row(16'sh7FFF, 1'b1),
      smp_row(16'sh8000, 1'b0),
      smp_row(16'sd1, 1'b0),
      smp_row(-16'sd1, 1'b1),
      smp_row(16'sd16384, 1'b0),
      // All dry at unity gain passes the sample through untouched.
      reg_row(tws_pkg::REG_BAL, 17'd65536),
      known_row(16'sh7FFF, 1'b0, 16'sh7FFF, 1'b0),
      known_row(16'sh8000, 1'b1, 16'sh8000, 1'b0),
      known_row(16'sd12345, 1'b0, 16'sd12345, 1'b0),
      // A gain of eight on the dry path drives both rails into saturation.
      reg_row(tws_pkg::REG_GAIN, 17'd32768),
      known_row(16'sh7FFF, 1'b0, 16'sh7FFF, 1'b1),
      known_row(16'sh8000, 1'b0, 16'sh8000, 1'b1),
      known_row(16'sd0, 1'b1, 16'sd0, 1'b0),
      // A balance above one is treated as all dry.
      reg_row(tws_pkg::REG_BAL, 17'h1FFFF),
      known_row(16'sd100, 1'b0, 16'sd800, 1'b0),
      known_row(-16'sd5000, 1'b0, 16'sh8000, 1'b1),
      // Full drive takes the argument beyond the table span: tanh is exactly
      // one, which rounds just above the positive rail but lands on the
      // negative one exactly.
      reg_row(tws_pkg::REG_GAIN, 17'd4096),
      reg_row(tws_pkg::REG_BAL, 17'd0),
      reg_row(tws_pkg::REG_DRIVE, 17'd65535),
      known_row(16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1),
      known_row(16'sh8000, 1'b0, 16'sh8000, 1'b0),
      smp_row(16'sd3, 1'b0),
      // The largest bias is itself past the span, so the positive side
      // cancels to nothing while the negative side swings by two.
      reg_row(tws_pkg::REG_BIAS, 17'h07FFF),
      known_row(16'sh7FFF, 1'b0, 16'sd0, 1'b0),
      known_row(16'sd0, 1'b0, 16'sd0, 1'b0),
      known_row(16'sh8000, 1'b1, 16'sh8000, 1'b1),
      reg_row(tws_pkg::REG_BIAS, 17'h08000),
      known_row(16'sd0, 1'b0, 16'sd0, 1'b0),
      known_row(16'sh7FFF, 1'b0, 16'sh7FFF, 1'b1),
      // Bits above each register's width must be dropped.
      reg_row(tws_pkg::REG_GAIN, 17'h11000),
      reg_row(tws_pkg::REG_DRIVE, 17'h10800),
      reg_row(tws_pkg::REG_BIAS, 17'h10400),
      reg_row(tws_pkg::REG_BAL, 17'h08000),
      smp_row(16'sd20000, 1'b0),
      smp_row(-16'sd20000, 1'b1),
      smp_row(16'sd0, 1'b0)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The directed part runs under the first idling profile: a sender that
    // rarely pauses and a receiver that mostly stalls.
    send_idle_pct = 21;
    recv_idle_pct = 79;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        if (rows[i].typed) begin
          want.sample  = rows[i].want_sample;
          want.clip    = rows[i].want_clip;
          want.blk_end = rows[i].blk_end;
        end else begin
          want = predict_mix(rows[i].sample, rows[i].blk_end);
        end
        offer_sample(rows[i].sample, rows[i].blk_end, want);
      end
    end

    // Random part. Phases 0, 1 and 3 pin registers at their extremes, the others
    // pick settings that keep most results off the rails.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          gv = 17'd65535; dv = 17'd0;     bv = 17'h08000; av = 17'd65536;
        end
        1: begin
          gv = 17'd0;     dv = 17'd65535; bv = 17'h07FFF; av = 17'h1FFFF;
        end
        3: begin
          gv = 17'd4096;  dv = 17'd65535; bv = 17'd0;     av = 17'd0;
        end
        default: begin
          gv = ($urandom_range(7) == 0) ? 17'($urandom_range(65535))
                                        : 17'($urandom_range(12288));
          dv = ($urandom_range(7) == 0) ? 17'($urandom_range(65535))
                                        : 17'($urandom_range(32768, 1024));
          bv = ($urandom_range(3) == 0) ? 17'($urandom_range(65535))
                                        : {1'b0, 16'($urandom_range(16384) - 8192)};
          av = ($urandom_range(7) == 0) ? 17'($urandom_range(131071, 65536))
                                        : 17'($urandom_range(65536));
        end
      endcase
      write_reg(tws_pkg::REG_GAIN, gv);
      write_reg(tws_pkg::REG_DRIVE, dv);
      write_reg(tws_pkg::REG_BIAS, bv);
      write_reg(tws_pkg::REG_BAL, av);

      // Idling profile: receiver-bound first, then sender-bound, then none.
      if (p < 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 79;
      end else if (p < 6) begin
        send_idle_pct = 79;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // With no idling on either side, a long receiver hold-off part way
        // through fills the pipeline while the sender keeps offering.
        if (p >= 6 && p <= 7 && n == 30) begin
          hold_requests++;
        end
        case ($urandom_range(7))
          0:       smp = ($urandom_range(1) == 1) ? 16'sh7FFF : 16'sh8000;
          1, 2:    smp = 16'($urandom_range(512) - 256);
          default: smp = 16'($urandom_range(65535));
        endcase
        be = ($urandom_range(15) == 0);
        offer_sample(smp, be, predict_mix(smp, be));
      end
    end

    // Let every outstanding result come home, then keep the clock running so that
    // anything spurious can show up.
    in_valid      <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain         = 0;
    while (pending_mix.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    if (pending_mix.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pending_mix.size()));
    end

    $display("Run covered %0d sample transactions, %0d results and %0d register writes,",
             items_sent, results_seen, reg_writes);
    $display("with rails, balance clamp, span limits and %0d cycles of input back-pressure.",
             input_stalls);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== tanh_waveshaper_mix.f =====
rtl/core/tws_pkg.sv
rtl/core/tws_tanh.sv
rtl/core/tanh_waveshaper_mix.sv
verif/tb_tanh_waveshaper_mix.sv
